/* rtl/assert_macros.svh */
// Shared assertion macros for the circle rasterizer checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, masked while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Implication that is also checked across reset.
`define ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("unconditional check failed");

`endif

/* rtl/fcr_pkg.sv */
package fcr_pkg;

  localparam int COORD_W    = 12;  // center coordinates, two's complement
  localparam int RADIUS_W   = 10;
  localparam int DIM_W      = 11;  // screen width and height registers
  localparam int STEP_W     = 11;  // scan step counters, up to 2r - 1
  localparam int POS_W      = 13;  // absolute scan position, signed
  localparam int SQ_W       = 20;  // squared distances
  localparam int ADDR_W     = 20;
  localparam int COLOR_W    = 32;
  localparam int APB_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int REG_SHIFT  = 2;   // registers sit on 32-bit word addresses

  localparam int SCREEN_RESET = 1024;

  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  typedef enum logic {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } reg_idx_t;

endpackage

/* rtl/fcr_ifs.sv */
interface fcr_cmd_if;
  import fcr_pkg::*;

  logic                       valid;
  logic                       ready;
  op_t                        operation;
  logic signed [COORD_W-1:0]  center_x;
  logic signed [COORD_W-1:0]  center_y;
  logic        [RADIUS_W-1:0] circle_radius;
  logic        [COLOR_W-1:0]  fill_color;

  modport source (
    output valid, operation, center_x, center_y, circle_radius, fill_color,
    input  ready
  );

  modport sink (
    input  valid, operation, center_x, center_y, circle_radius, fill_color,
    output ready
  );
endinterface

interface fcr_pix_if;
  import fcr_pkg::*;

  logic               valid;
  logic               ready;
  logic               pixel_write;
  logic [ADDR_W-1:0]  pixel_address;
  logic [COLOR_W-1:0] pixel_value;
  logic               scan_done;

  modport source (
    output valid, pixel_write, pixel_address, pixel_value, scan_done,
    input  ready
  );

  modport sink (
    input  valid, pixel_write, pixel_address, pixel_value, scan_done,
    output ready
  );
endinterface

/* rtl/filled_circle_rasterizer.sv */
// Filled circle rasterizer with a bounding-box scan.
// The cmd channel takes one beat per step: a start beat loads a circle
// (center, radius, color) and restarts any scan in progress; a tick beat
// visits the next position of the 2r by 2r box, row by row. Every cmd beat
// produces exactly one pix beat, which carries a framebuffer write (address
// row * screen_width + column, and the color) when the position is on screen
// and inside the circle, and scan_done on the last position or when idle.
// A beat's result is registered at the edge that accepts it and shown on pix
// from the next cycle. cmd takes one beat per clock while pix does not stall;
// the squared distances are kept as running sums, so each tick needs only
// adds, compares and one 11 by 11 bit multiply for the row address, which
// always uses the current screen_width. The multiplier for r * r sits in the
// start path. When pix stalls, the finished beat holds in the output register
// and cmd stays ready only if that register drains in the same cycle.
// Reset (rst, synchronous) empties the output register, stops any scan and
// sets both screen registers to 1024, limited to MAX_SCREEN_DIM.
// The APB port writes screen_width at address 0 and screen_height at 4; it
// should only be written while no beat is in flight.
module filled_circle_rasterizer #(
  parameter int MAX_SCREEN_DIM = 1024,
  parameter int MAX_RADIUS     = 1023,
  parameter int COLOR_BITS     = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  fcr_cmd_if.sink                         cmd,
  fcr_pix_if.source                       pix,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fcr_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [fcr_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [fcr_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import fcr_pkg::*;

  // Reset value of the screen registers, limited to the largest screen.
  localparam logic [DIM_W-1:0] DIM_RESET = (MAX_SCREEN_DIM < SCREEN_RESET) ?
                                           DIM_W'(MAX_SCREEN_DIM) : DIM_W'(SCREEN_RESET);

  // ---------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------
  logic [DIM_W-1:0] screen_width;
  logic [DIM_W-1:0] screen_height;
  logic [DIM_W-1:0] cfg_value;
  logic             cfg_write;
  reg_idx_t         cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = reg_idx_t'(paddr[REG_SHIFT]);
  // Only the low DIM_W bits are kept; above the largest screen they saturate.
  assign cfg_value = (32'(pwdata[DIM_W-1:0]) > MAX_SCREEN_DIM) ?
                     DIM_W'(MAX_SCREEN_DIM) : pwdata[DIM_W-1:0];

  always_comb begin
    case (cfg_index)
      REG_SCREEN_WIDTH:  prdata = APB_DATA_W'(screen_width);
      REG_SCREEN_HEIGHT: prdata = APB_DATA_W'(screen_height);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= DIM_RESET;
      screen_height <= DIM_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_value;
        REG_SCREEN_HEIGHT: screen_height <= cfg_value;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Scan state. Besides the step counters, the scan keeps its absolute
  // position, the offsets from the center and their squares as running
  // values.
  // ---------------------------------------------------------------------
  logic                      busy;
  logic [STEP_W-1:0]         row_step;
  logic [STEP_W-1:0]         column_step;
  logic [STEP_W-1:0]         side_m1;      // 2r - 1, the last step index
  logic signed [POS_W-1:0]   row_start_x;  // center_x - r
  logic signed [POS_W-1:0]   scan_x;
  logic signed [POS_W-1:0]   scan_y;
  logic signed [COORD_W-1:0] offset_x;     // scan_x - center_x
  logic signed [COORD_W-1:0] offset_y;
  logic [SQ_W-1:0]           offset_x_sq;
  logic [SQ_W-1:0]           offset_y_sq;
  logic [SQ_W-1:0]           radius_sq;
  logic [COLOR_BITS-1:0]     held_color;

  logic cmd_fire;
  logic is_start;

  assign cmd.ready = !pix.valid || pix.ready;
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign is_start  = (cmd.operation == OP_START);

  // Start path: saturate the radius and set up the first scan position.
  logic [RADIUS_W-1:0]             start_radius;
  logic signed [POS_W-1:0]         start_x0;
  logic signed [POS_W-1:0]         start_y0;
  logic signed [COORD_W-1:0]       start_offset;
  logic [SQ_W-1:0]                 start_radius_sq;

  assign start_radius = (32'(cmd.circle_radius) > MAX_RADIUS) ?
                        RADIUS_W'(MAX_RADIUS) : cmd.circle_radius;
  assign start_x0 = POS_W'(cmd.center_x) - POS_W'($signed({1'b0, start_radius}));
  assign start_y0 = POS_W'(cmd.center_y) - POS_W'($signed({1'b0, start_radius}));
  assign start_offset      = -COORD_W'($signed({1'b0, start_radius}));
  assign start_radius_sq   = SQ_W'(start_radius) * SQ_W'(start_radius);

  // Tick path: clip against the screen and test against the circle.
  logic                 on_screen;
  logic                 in_circle;
  logic                 column_last;
  logic                 scan_last;
  logic [2*DIM_W-1:0]   row_product;
  logic [ADDR_W-1:0]    tick_address;
  logic [SQ_W-1:0]      offset_x_sq_next;
  logic [SQ_W-1:0]      offset_y_sq_next;

  assign on_screen = !scan_y[POS_W-1] && (scan_y < $signed({2'b00, screen_height})) &&
                     !scan_x[POS_W-1] && (scan_x < $signed({2'b00, screen_width}));
  assign in_circle = ({1'b0, offset_x_sq} + {1'b0, offset_y_sq}) <= {1'b0, radius_sq};
  assign column_last  = (column_step == side_m1);
  assign scan_last    = column_last && (row_step == side_m1);
  // The address only matters on screen, where both coordinates fit in DIM_W
  // bits and are not negative.
  assign row_product  = scan_y[DIM_W-1:0] * screen_width;
  assign tick_address = ADDR_W'(row_product) + ADDR_W'(scan_x[DIM_W-1:0]);

  // (d + 1)^2 = d^2 + 2d + 1
  assign offset_x_sq_next = SQ_W'($signed({1'b0, offset_x_sq}) + $signed({offset_x, 1'b1}));
  assign offset_y_sq_next = SQ_W'($signed({1'b0, offset_y_sq}) + $signed({offset_y, 1'b1}));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      row_step    <= '0;
      column_step <= '0;
    end else if (cmd_fire) begin
      if (is_start) begin
        busy        <= (start_radius != '0);
        row_step    <= '0;
        column_step <= '0;
      end else if (busy) begin
        if (scan_last) begin
          busy        <= 1'b0;
          row_step    <= '0;
          column_step <= '0;
        end else if (column_last) begin
          column_step <= '0;
          row_step    <= row_step + STEP_W'(1);
        end else begin
          column_step <= column_step + STEP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      if (is_start) begin
        side_m1     <= STEP_W'({start_radius, 1'b0}) - STEP_W'(1);
        row_start_x <= start_x0;
        scan_x      <= start_x0;
        scan_y      <= start_y0;
        offset_x    <= start_offset;
        offset_y    <= start_offset;
        offset_x_sq <= start_radius_sq;
        offset_y_sq <= start_radius_sq;
        radius_sq   <= start_radius_sq;
        held_color  <= cmd.fill_color[COLOR_BITS-1:0];
      end else if (busy && !scan_last) begin
        if (column_last) begin
          // Back to the left edge of the next row.
          scan_x      <= row_start_x;
          offset_x    <= -COORD_W'($signed({1'b0, side_m1[STEP_W-1:1]})) - COORD_W'(1);
          offset_x_sq <= radius_sq;
          scan_y      <= scan_y + POS_W'(1);
          offset_y    <= offset_y + COORD_W'(1);
          offset_y_sq <= offset_y_sq_next;
        end else begin
          scan_x      <= scan_x + POS_W'(1);
          offset_x    <= offset_x + COORD_W'(1);
          offset_x_sq <= offset_x_sq_next;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result for the current beat and the output register.
  // ---------------------------------------------------------------------
  logic               res_write;
  logic [ADDR_W-1:0]  res_address;
  logic [COLOR_W-1:0] res_value;
  logic               res_done;

  always_comb begin
    res_write   = 1'b0;
    res_address = '0;
    res_value   = '0;
    res_done    = 1'b1;
    if (is_start) begin
      // A zero radius finishes at once.
      res_done = (start_radius == '0);
    end else if (busy) begin
      res_write = on_screen && in_circle;
      res_done  = scan_last;
      if (res_write) begin
        res_address = tick_address;
        res_value   = COLOR_W'(held_color);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix.valid <= 1'b0;
    end else if (cmd.ready) begin
      pix.valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      pix.pixel_write   <= res_write;
      pix.pixel_address <= res_address;
      pix.pixel_value   <= res_value;
      pix.scan_done     <= res_done;
    end
  end

endmodule

/* rtl/fcr_checker.sv */
`include "assert_macros.svh"

module fcr_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        cmd_valid,
  input logic                        cmd_ready,
  input logic                        pix_valid,
  input logic                        pix_ready,
  input logic                        pix_write,
  input logic [fcr_pkg::ADDR_W-1:0]  pix_address,
  input logic [fcr_pkg::COLOR_W-1:0] pix_value,
  input logic                        pix_done
);
  import fcr_pkg::*;

  // A pix beat that waits for the receiver keeps its contents.
  `ASSERT_NEXT(a_pix_hold, clk, rst, pix_valid && !pix_ready,
    pix_valid && $stable(pix_write) && $stable(pix_address) && $stable(pix_value) && $stable(pix_done))

  // Every accepted cmd beat shows up as a pix beat in the next cycle.
  `ASSERT_NEXT(a_one_result, clk, rst, cmd_valid && cmd_ready, pix_valid)

  // cmd is held off only by a full output register that is not draining.
  `ASSERT_IMPLIES(a_ready_cause, clk, rst, !cmd_ready, pix_valid && !pix_ready)

  // Reset empties the output register.
  `ASSERT_ALWAYS(a_reset_empty, clk, $past(rst), !pix_valid)

endmodule

bind filled_circle_rasterizer fcr_checker u_fcr_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd.valid),
  .cmd_ready   (cmd.ready),
  .pix_valid   (pix.valid),
  .pix_ready   (pix.ready),
  .pix_write   (pix.pixel_write),
  .pix_address (pix.pixel_address),
  .pix_value   (pix.pixel_value),
  .pix_done    (pix.scan_done)
);

/* verif/filled_circle_rasterizer_test.sv */
module filled_circle_rasterizer_test;
  import fcr_pkg::*;

  // The block is built with its default parameters, so the model below uses
  // the same limits.
  localparam int MAX_SCREEN_DIM = 1024;

  // The watchdog gives up after this many cycles without a beat on either
  // channel. The longest correct quiet spell is the long hold-off on pix.
  localparam int STALL_LIMIT  = 2000;
  localparam int CHOKE_CYCLES = 120;

  // One cmd beat as the sender sees it.
  typedef struct {
    op_t                       op;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [RADIUS_W-1:0]       radius;
    logic [COLOR_W-1:0]        color;
  } cmd_t;

  // One pix beat, field for field as the block drives it.
  typedef struct {
    logic               pixel_write;
    logic [ADDR_W-1:0]  pixel_address;
    logic [COLOR_W-1:0] pixel_value;
    logic               scan_done;
  } pix_t;

  logic clk;
  logic rst;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  fcr_cmd_if cmd_bus ();
  fcr_pix_if pix_bus ();

  filled_circle_rasterizer i_dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_bus),
    .pix     (pix_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Beats waiting to be offered on cmd, and the pix beats that the accepted
  // cmd beats have earned so far, oldest first.
  cmd_t cmd_backlog[$];
  pix_t pixel_beats_due[$];

  // Progress counters. beats_queued is written by the stimulus process only;
  // the other two are written with nonblocking assignments by the driver and
  // the monitor, so the stimulus process always sees settled values.
  int beats_queued  = 0;
  int beats_taken   = 0;
  int beats_checked = 0;
  int mismatch_count = 0;

  // Gap and hold-off control. calm turns off all random idling for the last
  // part of the run; each bump of choke_count asks the monitor for one long
  // hold-off on pix.
  logic calm        = 1'b0;
  int   choke_count = 0;
  int   choke_seen  = 0;
  int   send_gap    = 0;
  int   ready_gap   = 0;
  int   quiet_cycles = 0;

  cmd_t next_cmd;
  cmd_t taken;
  pix_t want;

  // Mirror of the block: screen registers and scan state.
  int               screen_w = SCREEN_RESET;
  int               screen_h = SCREEN_RESET;
  logic             scan_active = 1'b0;
  int               scan_row = 0;
  int               scan_col = 0;
  int               circle_cx = 0;
  int               circle_cy = 0;
  int               circle_r = 0;
  logic [COLOR_W-1:0] circle_color = '0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Computes the pix beat that one accepted cmd beat earns and moves the scan
  // state on. A start loads the circle and restarts the scan; its only
  // visible effect is scan_done, which is high when the radius is zero. A
  // tick visits the next position of the 2r by 2r box whose top left corner
  // is the center minus r, and writes the color there when the position is
  // on screen and no farther than r from the center. The last row and
  // column of the box (center plus r) are never visited.
  function automatic pix_t rasterize_step(cmd_t c);
    pix_t p;
    int   side;
    int   sx;
    int   sy;
    int   dx;
    int   dy;
    logic on_screen;
    logic in_circle;
    logic last;
    p = '{pixel_write: 1'b0, pixel_address: '0, pixel_value: '0, scan_done: 1'b0};
    if (c.op == OP_START) begin
      circle_cx    = c.cx;
      circle_cy    = c.cy;
      circle_r     = c.radius;
      circle_color = c.color;
      scan_row     = 0;
      scan_col     = 0;
      scan_active  = (c.radius != 0);
      p.scan_done  = (c.radius == 0);
    end else if (!scan_active) begin
      p.scan_done = 1'b1;
    end else begin
      side = 2 * circle_r;
      sy = circle_cy - circle_r + scan_row;
      sx = circle_cx - circle_r + scan_col;
      dx = sx - circle_cx;
      dy = sy - circle_cy;
      on_screen = (sy >= 0) && (sy < screen_h) && (sx >= 0) && (sx < screen_w);
      in_circle = (dx * dx + dy * dy) <= (circle_r * circle_r);
      last = (scan_row + 1 >= side) && (scan_col + 1 >= side);
      if (on_screen && in_circle) begin
        p.pixel_write   = 1'b1;
        p.pixel_address = ADDR_W'(sy * screen_w + sx);
        p.pixel_value   = circle_color;
      end
      p.scan_done = last;
      if (last) begin
        scan_active = 1'b0;
        scan_row    = 0;
        scan_col    = 0;
      end else if (scan_col + 1 >= side) begin
        scan_col = 0;
        scan_row = scan_row + 1;
      end else begin
        scan_col = scan_col + 1;
      end
    end
    return p;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("MISMATCH at pix beat %0d: %s", beats_checked, what);
    mismatch_count++;
  endtask

  // A tick carries random junk in the circle fields; the block must ignore it.
  function automatic cmd_t tick_item();
    cmd_t c;
    c.op     = OP_TICK;
    c.cx     = COORD_W'($urandom);
    c.cy     = COORD_W'($urandom);
    c.radius = RADIUS_W'($urandom);
    c.color  = $urandom;
    return c;
  endfunction

  function automatic cmd_t start_item(input int cx, input int cy, input int r,
                                      input logic [COLOR_W-1:0] color);
    cmd_t c;
    c.op     = OP_START;
    c.cx     = COORD_W'(cx);
    c.cy     = COORD_W'(cy);
    c.radius = RADIUS_W'(r);
    c.color  = color;
    return c;
  endfunction

  task automatic queue_item(input cmd_t c);
    cmd_backlog.push_back(c);
    beats_queued++;
  endtask

  // Queues one start beat and the ticks that follow it. Most circles are small
  // and scanned to the end, with a few idle ticks after the last position.
  // Some are cut short by the next start, which exercises a restart in the
  // middle of a scan. Large radii are always cut short, since a full scan
  // would take far more ticks than are queued for them. Centers mostly land
  // within r + 2 of the screen, so boxes can straddle its edges; now and
  // then they are random over the whole coordinate range.
  task automatic queue_circle(output int added);
    int          r;
    int          area;
    int          ticks;
    int unsigned pick;
    cmd_t        c;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      r = 0;
    end else if (pick < 76) begin
      r = $urandom_range(1, 4);
    end else if (pick < 92) begin
      r = $urandom_range(5, 8);
    end else begin
      r = $urandom_range(9, (1 << RADIUS_W) - 1);
    end
    c = tick_item();
    c.op     = OP_START;
    c.radius = RADIUS_W'(r);
    if ($urandom_range(0, 15) != 0) begin
      c.cx = COORD_W'(int'($urandom_range(0, screen_w + 2 * r + 4)) - r - 2);
      c.cy = COORD_W'(int'($urandom_range(0, screen_h + 2 * r + 4)) - r - 2);
    end
    queue_item(c);
    area = 4 * r * r;
    if (r > 8) begin
      ticks = $urandom_range(0, 40);
    end else if (area == 0 || $urandom_range(0, 9) < 7) begin
      ticks = area + $urandom_range(0, 2);
    end else begin
      ticks = $urandom_range(0, area - 1);
    end
    repeat (ticks) queue_item(tick_item());
    added = ticks + 1;
  endtask

  // APB write: setup, then access until pready. The model takes the new value
  // once the write edge has passed.
  task automatic write_screen_reg(input reg_idx_t idx, input int unsigned value);
    int unsigned dim;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(int'(idx) << REG_SHIFT);
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // Only eleven bits are kept, and anything above the largest screen
    // saturates.
    dim = value & 32'h7FF;
    if (dim > MAX_SCREEN_DIM) begin
      dim = MAX_SCREEN_DIM;
    end
    if (idx == REG_SCREEN_WIDTH) begin
      screen_w = dim;
    end else begin
      screen_h = dim;
    end
  endtask

  // Waits until every queued beat has been taken and every pix beat it
  // earned has been checked.
  task automatic wait_for_idle();
    while (beats_taken != beats_queued || beats_checked != beats_queued) begin
      @(posedge clk);
    end
  endtask

  // One stretch of the run under one screen setting. The registers are only
  // written once nothing is in flight, and every phase closes with a start of
  // radius zero so that no scan is left half done across a register change.
  task automatic run_phase(input int unsigned width, input int unsigned height,
                           input int items, input logic choke, input logic quiet);
    int added;
    int total;
    wait_for_idle();
    write_screen_reg(REG_SCREEN_WIDTH, width);
    write_screen_reg(REG_SCREEN_HEIGHT, height);
    @(posedge clk);
    calm <= quiet;
    @(negedge clk);
    total = 0;
    while (total < items) begin
      queue_circle(added);
      total += added;
    end
    queue_item(start_item(0, 0, 0, $urandom));
    if (choke) begin
      // Hold pix off for a long stretch while cmd keeps offering beats, so
      // the output register fills and cmd must stall.
      @(posedge clk);
      choke_count <= choke_count + 1;
    end
  endtask

  // Driver: offers beats from the backlog on cmd. When a beat is taken, the
  // model works out the pix beat it earns right away. valid and the payload
  // only change when no beat is on offer or the current one was just taken.
  always @(posedge clk) begin
    if (rst) begin
      cmd_bus.valid <= 1'b0;
      send_gap      <= 0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        taken.op     = cmd_bus.operation;
        taken.cx     = cmd_bus.center_x;
        taken.cy     = cmd_bus.center_y;
        taken.radius = cmd_bus.circle_radius;
        taken.color  = cmd_bus.fill_color;
        pixel_beats_due.push_back(rasterize_step(taken));
        beats_taken <= beats_taken + 1;
      end
      if (!cmd_bus.valid || cmd_bus.ready) begin
        if (send_gap != 0) begin
          send_gap      <= send_gap - 1;
          cmd_bus.valid <= 1'b0;
        end else if (!calm && cmd_backlog.size() != 0 && $urandom_range(0, 13) == 0) begin
          // Start a random gap with valid low.
          send_gap      <= $urandom_range(0, 8);
          cmd_bus.valid <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          next_cmd = cmd_backlog.pop_front();
          cmd_bus.valid         <= 1'b1;
          cmd_bus.operation     <= next_cmd.op;
          cmd_bus.center_x      <= next_cmd.cx;
          cmd_bus.center_y      <= next_cmd.cy;
          cmd_bus.circle_radius <= next_cmd.radius;
          cmd_bus.fill_color    <= next_cmd.color;
        end else begin
          cmd_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each pix beat against the oldest pending expectation and
  // drives ready, with short random stalls and the occasional long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      pix_bus.ready <= 1'b0;
      ready_gap     <= 0;
    end else begin
      if (pix_bus.valid && pix_bus.ready) begin
        beats_checked <= beats_checked + 1;
        if (pixel_beats_due.size() == 0) begin
          flag_mismatch("pix beat with nothing expected");
        end else begin
          want = pixel_beats_due.pop_front();
          if (pix_bus.pixel_write !== want.pixel_write) begin
            flag_mismatch($sformatf("pixel_write %0b, expected %0b",
                                    pix_bus.pixel_write, want.pixel_write));
          end
          if (pix_bus.pixel_address !== want.pixel_address) begin
            flag_mismatch($sformatf("pixel_address %0d, expected %0d",
                                    pix_bus.pixel_address, want.pixel_address));
          end
          if (pix_bus.pixel_value !== want.pixel_value) begin
            flag_mismatch($sformatf("pixel_value %h, expected %h",
                                    pix_bus.pixel_value, want.pixel_value));
          end
          if (pix_bus.scan_done !== want.scan_done) begin
            flag_mismatch($sformatf("scan_done %0b, expected %0b",
                                    pix_bus.scan_done, want.scan_done));
          end
        end
      end
      if (choke_seen != choke_count) begin
        choke_seen    <= choke_count;
        ready_gap     <= CHOKE_CYCLES;
        pix_bus.ready <= 1'b0;
      end else if (ready_gap != 0) begin
        ready_gap     <= ready_gap - 1;
        pix_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        // Start a random stall with ready low.
        ready_gap     <= $urandom_range(0, 8);
        pix_bus.ready <= 1'b0;
      end else begin
        pix_bus.ready <= 1'b1;
      end
    end
  end

  // Watchdog: a long spell with no beat on either channel means the block
  // has hung or dropped a beat.
  always @(posedge clk) begin
    if (rst || (cmd_bus.valid && cmd_bus.ready) || (pix_bus.valid && pix_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst                   = 1'b1;
    cmd_bus.valid         = 1'b0;
    cmd_bus.operation     = OP_TICK;
    cmd_bus.center_x      = '0;
    cmd_bus.center_y      = '0;
    cmd_bus.circle_radius = '0;
    cmd_bus.fill_color    = '0;
    pix_bus.ready         = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed opening under the reset screen of 1024 by 1024. A tick while
    // idle reports scan_done alone. A start of radius zero at the extreme
    // corners of the coordinate range finishes at once.
    queue_item(tick_item());
    queue_item(start_item(-2048, 2047, 0, 32'hFFFF_FFFF));
    // Unit circle at the origin: three of its four positions are off screen
    // and only the center itself is written.
    queue_item(start_item(0, 0, 1, 32'h0000_0000));
    repeat (4) queue_item(tick_item());
    // Largest radius at the opposite corners, cut short after two ticks by a
    // restart while busy.
    queue_item(start_item(2047, -2048, 1023, 32'h5A5A_5A5A));
    repeat (2) queue_item(tick_item());
    // Radius two at the bottom right corner of the screen: the box runs off
    // both the right and the bottom edge. Then one idle tick after the end.
    queue_item(start_item(1023, 1023, 2, 32'hA5A5_A5A5));
    repeat (17) queue_item(tick_item());

    // Random phases over a range of screen settings, the smallest and the
    // saturating ones among them. The last phase runs with no idling.
    run_phase(16, 12, 300, 1'b1, 1'b0);
    run_phase(1, 1, 150, 1'b0, 1'b0);
    run_phase(0, 9, 120, 1'b0, 1'b0);
    run_phase(2047, 1024, 330, 1'b0, 1'b0);
    run_phase(37, 1024, 300, 1'b0, 1'b0);
    run_phase(1024, 5, 500, 1'b0, 1'b1);

    wait_for_idle();
    // Give a late or extra pix beat a chance to show up.
    repeat (4) @(posedge clk);
    if (pixel_beats_due.size() != 0) begin
      flag_mismatch($sformatf("%0d expected pix beats never arrived",
                              pixel_beats_due.size()));
    end
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
